// ===== src/wema_pkg.sv =====
// Shared types, constants and the saturating-increment helper of the weighted-error medium arbiter.
package wema_pkg;

   // Number of error fields carried by one request transfer.
   localparam int unsigned ERR_FIELDS = 4;

   typedef logic signed [15:0] error_type;
   typedef logic        [15:0] weight_type;
   typedef logic        [15:0] mag_type;
   typedef logic        [31:0] score_type;
   typedef logic        [31:0] count_type;
   typedef logic        [14:0] peak_type;
   typedef logic        [2:0]  active_type;
   typedef logic        [1:0]  node_type;
   typedef logic        [ERR_FIELDS-1:0] mask_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_NODE_COUNT = 3'd0,
      CSR_WEIGHT_0   = 3'd1,
      CSR_WEIGHT_1   = 3'd2,
      CSR_WEIGHT_2   = 3'd3,
      CSR_WEIGHT_3   = 3'd4
   } csr_index_type;

   localparam active_type NODE_COUNT_RESET = 3'd4;
   localparam weight_type WEIGHT_RESET     = 16'd256;
   localparam count_type  CNT_MAX          = 32'hFFFF_FFFF;

   // Increment that holds at the all-ones value.
   function automatic count_type sat_inc(input count_type value);
      return (value == CNT_MAX) ? value : value + 32'd1;
   endfunction

endpackage

// ===== src/wema_req_if.sv =====
// Request channel: one contention round per transfer.
interface wema_req_if import wema_pkg::*; ();
   logic       valid;
   logic       ready;
   active_type active_count;
   node_type   query_node;
   error_type  error_0;
   error_type  error_1;
   error_type  error_2;
   error_type  error_3;

   modport source (output valid, active_count, query_node, error_0, error_1, error_2, error_3,
                   input ready);
   modport sink   (input valid, active_count, query_node, error_0, error_1, error_2, error_3,
                   output ready);
endinterface

// ===== src/wema_rsp_if.sv =====
// Response channel: winner and statistics of one round.
interface wema_rsp_if import wema_pkg::*; ();
   logic      valid;
   logic      ready;
   node_type  winner;
   logic      winner_valid;
   count_type win_count;
   count_type discard_count;
   count_type round_total;
   peak_type  peak_error;

   modport source (output valid, winner, winner_valid, win_count, discard_count,
                   round_total, peak_error,
                   input ready);
   modport sink   (input valid, winner, winner_valid, win_count, discard_count,
                   round_total, peak_error,
                   output ready);
endinterface

// ===== src/weighted_error_medium_arbiter_top.sv =====
// Weighted-error medium arbiter: single-pass round logic with APB-style register port.
//
// The arbiter accepts one request transfer every clock cycle while the response side
// is not stalled and returns exactly one response transfer per request. The request is
// held in an input register; from there one pass of combinational logic forms the four
// weight-times-magnitude scores (one 16x16 multiplier per node) and the active mask,
// picks the lowest-indexed highest score, and works out the saturating win, discard
// and round counters and the error peak, which are written together with the response
// register at the next edge. A request passes through the input register and then the
// response register before its response is presented, and the response completes at a
// clock edge when the response side is ready. The counter and peak update is the only
// path that feeds back on itself, and it allows a throughput of one round per cycle
// while the response side is not stalled. A stall on the response side backs up into
// the input register without losing a transfer. Registers: node_count at byte address 0,
// weight_0..weight_3 at 4..16; writes to other addresses are dropped and read as zero.
module weighted_error_medium_arbiter_top
   import wema_pkg::*;
#(
   parameter int unsigned NODES = 4
) (
   input  logic        clock,
   input  logic        reset,
   wema_req_if.sink    req,
   wema_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Nodes that can ever contend: limited by the storage and by the error fields.
   localparam int unsigned CNT_NODES = (NODES < ERR_FIELDS) ? NODES : ERR_FIELDS;
   localparam active_type  LIM_MAX   = active_type'(CNT_NODES);

   // Configuration registers.
   active_type node_count_ff;
   weight_type weight_ff [ERR_FIELDS];
   logic       csr_write;
   csr_index_type csr_index;

   // Input register.
   logic       s1_valid_ff;
   active_type s1_active_ff;
   node_type   s1_query_ff;
   error_type  s1_error_ff [ERR_FIELDS];

   // Response register.
   logic       out_valid_ff;
   node_type   out_winner_ff;
   logic       out_winner_valid_ff;
   count_type  out_win_ff;
   count_type  out_discard_ff;
   count_type  out_round_ff;
   peak_type   out_peak_ff;

   // Arbiter state.
   count_type  win_counts_ff     [CNT_NODES];
   count_type  discard_counts_ff [CNT_NODES];
   count_type  round_count_ff;
   peak_type   peak_seen_ff;

   // Flow control.
   logic out_free;
   logic s1_free;
   logic s1_move;
   logic req_take;

   // Scores of the held round.
   active_type lim;
   active_type active_clip;
   mask_type   act_mask;
   score_type  score [ERR_FIELDS];
   peak_type   peak_cand;
   mag_type    mag;

   // Winner and updated statistics.
   logic       round;
   node_type   win;
   score_type  best;
   count_type  win_counts_in     [CNT_NODES];
   count_type  discard_counts_in [CNT_NODES];
   count_type  round_count_in;
   peak_type   peak_seen_in;
   count_type  win_sel;
   count_type  discard_sel;

   // Register port: writes complete in the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         for (int i = 0; i < ERR_FIELDS; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_pwdata[2:0];
            CSR_WEIGHT_0:   weight_ff[0]  <= csr_pwdata[15:0];
            CSR_WEIGHT_1:   weight_ff[1]  <= csr_pwdata[15:0];
            CSR_WEIGHT_2:   weight_ff[2]  <= csr_pwdata[15:0];
            CSR_WEIGHT_3:   weight_ff[3]  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_NODE_COUNT: csr_prdata = {29'd0, node_count_ff};
         CSR_WEIGHT_0:   csr_prdata = {16'd0, weight_ff[0]};
         CSR_WEIGHT_1:   csr_prdata = {16'd0, weight_ff[1]};
         CSR_WEIGHT_2:   csr_prdata = {16'd0, weight_ff[2]};
         CSR_WEIGHT_3:   csr_prdata = {16'd0, weight_ff[3]};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // The held round moves on when the response register is empty or emptying.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req.ready = s1_free;
   assign req_take  = req.valid && s1_free;

   // Input register: hold the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_active_ff   <= req.active_count;
         s1_query_ff    <= req.query_node;
         s1_error_ff[0] <= req.error_0;
         s1_error_ff[1] <= req.error_1;
         s1_error_ff[2] <= req.error_2;
         s1_error_ff[3] <= req.error_3;
      end
   end

   // Clip the active count, then score every node and find the nonnegative peak.
   always_comb begin
      if (node_count_ff == 3'd0) begin
         lim = 3'd1;
      end else if (node_count_ff > LIM_MAX) begin
         lim = LIM_MAX;
      end else begin
         lim = node_count_ff;
      end
      active_clip = (s1_active_ff > lim) ? lim : s1_active_ff;
      peak_cand   = '0;
      mag         = '0;
      for (int i = 0; i < ERR_FIELDS; i++) begin
         act_mask[i] = active_type'(i) < active_clip;
         // The magnitude of the most negative error still fits in 16 unsigned bits.
         mag         = s1_error_ff[i][15] ? mag_type'(-s1_error_ff[i])
                                          : mag_type'(s1_error_ff[i]);
         score[i]    = weight_ff[i] * mag;
         if (act_mask[i] && !s1_error_ff[i][15] && (s1_error_ff[i][14:0] > peak_cand)) begin
            peak_cand = s1_error_ff[i][14:0];
         end
      end
   end

   // Pick the winner and work out the updated statistics.
   always_comb begin
      round = act_mask[0];
      win   = '0;
      best  = score[0];
      // Strictly greater keeps the lowest index on a tie.
      for (int i = 1; i < ERR_FIELDS; i++) begin
         if (act_mask[i] && (score[i] > best)) begin
            best = score[i];
            win  = node_type'(i);
         end
      end

      win_sel     = '0;
      discard_sel = '0;
      for (int i = 0; i < CNT_NODES; i++) begin
         win_counts_in[i]     = win_counts_ff[i];
         discard_counts_in[i] = discard_counts_ff[i];
         if (act_mask[i]) begin
            if (win == node_type'(i)) begin
               win_counts_in[i] = sat_inc(win_counts_ff[i]);
            end else begin
               discard_counts_in[i] = sat_inc(discard_counts_ff[i]);
            end
         end
         if (s1_query_ff == node_type'(i)) begin
            win_sel     = win_counts_in[i];
            discard_sel = discard_counts_in[i];
         end
      end

      round_count_in = round ? sat_inc(round_count_ff) : round_count_ff;
      peak_seen_in   = (peak_cand > peak_seen_ff) ? peak_cand : peak_seen_ff;
   end

   // Arbiter state advances with each round leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CNT_NODES; i++) begin
            win_counts_ff[i]     <= '0;
            discard_counts_ff[i] <= '0;
         end
         round_count_ff <= '0;
         peak_seen_ff   <= '0;
      end else if (s1_move) begin
         win_counts_ff     <= win_counts_in;
         discard_counts_ff <= discard_counts_in;
         round_count_ff    <= round_count_in;
         peak_seen_ff      <= peak_seen_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_winner_ff       <= win;
         out_winner_valid_ff <= round;
         out_win_ff          <= win_sel;
         out_discard_ff      <= discard_sel;
         out_round_ff        <= round_count_in;
         out_peak_ff         <= peak_seen_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.winner        = out_winner_ff;
   assign rsp.winner_valid  = out_winner_valid_ff;
   assign rsp.win_count     = out_win_ff;
   assign rsp.discard_count = out_discard_ff;
   assign rsp.round_total   = out_round_ff;
   assign rsp.peak_error    = out_peak_ff;

endmodule
